/* src/step_sequenced_gain_gate_defines.svh */
// assertion macros for the step sequenced gain gate
`ifndef STEP_SEQUENCED_GAIN_GATE_DEFINES_SVH
`define STEP_SEQUENCED_GAIN_GATE_DEFINES_SVH

`ifndef SYNTH
`define SSGG_ASSERT(label, clk_i, rst_ni, prop) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
		else $error("ssgg assertion failed");
`define SSGG_ASSERT_NR(label, clk_i, prop) \
	label: assert property (@(posedge clk_i) prop) \
		else $error("ssgg assertion failed");
`else
`define SSGG_ASSERT(label, clk_i, rst_ni, prop)
`define SSGG_ASSERT_NR(label, clk_i, prop)
`endif

`endif

/* src/ssgg_pkg.sv */
// shared types, constants and helpers of the step sequenced gain gate
`timescale 1ns / 1ps
`default_nettype none

package ssgg_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int INC_W      = 25;
	localparam int STEPS_W    = 5;
	localparam int SPAN_W     = 17;
	localparam int LEVELS_W   = 64;
	localparam int SYNC_W     = 24;
	localparam int GAIN_W     = 18;
	localparam int STEP_OUT_W = 4;
	localparam int FRAC_W     = 16;
	localparam int MUL_B_W    = 18;
	localparam int QUO_W      = 17;
	localparam int NUM_W      = 32;
	localparam int LVL_IDX_W  = 7;

	localparam logic [SPAN_W-1:0] SPAN_MIN = 17'd655;
	localparam logic [SPAN_W-1:0] SPAN_ONE = 17'd65536;

	localparam logic [INC_W-1:0]    RST_PHASE_INC  = '0;
	localparam logic [STEPS_W-1:0]  RST_STEP_COUNT = 5'd16;
	localparam logic [SPAN_W-1:0]   RST_SPAN       = 17'd13107;
	localparam logic [LEVELS_W-1:0] RST_LEVELS     = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PHASE_INC    = 3'd0,
		REG_STEP_COUNT   = 3'd1,
		REG_ATTACK_SPAN  = 3'd2,
		REG_RELEASE_SPAN = 3'd3,
		REG_LEVELS_LOW   = 3'd4,
		REG_LEVELS_HIGH  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [INC_W-1:0]    phase_inc;
		logic [STEPS_W-1:0]  step_count;
		logic [SPAN_W-1:0]   attack_span;
		logic [SPAN_W-1:0]   release_span;
		logic [LEVELS_W-1:0] levels_low;
		logic [LEVELS_W-1:0] levels_high;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [SPAN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quot;
	} div_rsp_t;

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [SPAN_W-1:0] clamp_span(input logic [SPAN_W-1:0] v);
		logic [SPAN_W-1:0] r;
		r = v;
		if (v < SPAN_MIN) r = SPAN_MIN;
		if (v > SPAN_ONE) r = SPAN_ONE;
		return r;
	endfunction

	// q1.7 byte of a step, capped at one, as q1.16
	function automatic logic [SPAN_W-1:0] level_of(input logic [LEVELS_W-1:0] lo,
		input logic [LEVELS_W-1:0] hi, input logic [LVL_IDX_W-1:0] i);
		logic [7:0] b;
		b = 8'd0;
		if (i < 7'd8) begin
			b = lo[{i[2:0], 3'b000} +: 8];
		end else if (i < 7'd16) begin
			b = hi[{i[2:0], 3'b000} +: 8];
		end
		if (b > 8'd128) b = 8'd128;
		return {b, 9'd0};
	endfunction

endpackage

`default_nettype wire

/* src/ssgg_mul.sv */
// shared signed multiplier with a registered product
`timescale 1ns / 1ps
`default_nettype none

module ssgg_mul #(
	parameter int A_W = 33
) (
	input  logic                                  clk,
	input  logic signed [A_W-1:0]                 op_a,
	input  logic signed [ssgg_pkg::MUL_B_W-1:0]   op_b,
	output logic signed [A_W+ssgg_pkg::MUL_B_W-1:0] product
);
	import ssgg_pkg::*;

	logic signed [A_W+MUL_B_W-1:0] product_q;

	always_ff @(posedge clk) begin
		product_q <= op_a * op_b;
	end

	assign product = product_q;

endmodule

`default_nettype wire

/* src/ssgg_div.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module ssgg_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ssgg_pkg::div_req_t req,
	output ssgg_pkg::div_rsp_t rsp
);
	import ssgg_pkg::*;

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SPAN_W-1:0] rem_q;
	logic [QUO_W-1:0]  num_q;
	logic [SPAN_W-1:0] den_q;
	logic [QUO_W-1:0]  quot_q;
	logic [SPAN_W+1:0] diff;
	logic              ge;
	logic              done;

	always_comb begin
		diff = {1'b0, rem_q, num_q[QUO_W-1]} - {2'b00, den_q};
		ge   = !diff[SPAN_W+1];
		done = busy_q && (cnt_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(QUO_W);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// quotient fits in QUO_W bits, so the top bits seed the remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= SPAN_W'(req.num[NUM_W-1:QUO_W]);
			num_q  <= req.num[QUO_W-1:0];
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q && !done) begin
			rem_q  <= ge ? diff[SPAN_W-1:0] : {rem_q[SPAN_W-2:0], num_q[QUO_W-1]};
			num_q  <= {num_q[QUO_W-2:0], 1'b0};
			quot_q <= {quot_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.done = done;
	assign rsp.quot = quot_q;

endmodule

`default_nettype wire

/* src/ssgg_seq.sv */
// sequencer: phase, step tracking, ramps and scaling over the shared units
`timescale 1ns / 1ps
`default_nettype none

module ssgg_seq #(
	parameter int MAX_STEPS   = 16,
	parameter int PHASE_BITS  = 24,
	parameter int SAMPLE_BITS = 24,
	parameter int MUL_A_W     = 33
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  ssgg_pkg::cfg_t                              cfg,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  logic signed [SAMPLE_BITS-1:0]               sample_left,
	input  logic signed [SAMPLE_BITS-1:0]               sample_right,
	input  logic                                        sync_valid,
	input  logic [ssgg_pkg::SYNC_W-1:0]                 sync_phase,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output logic signed [SAMPLE_BITS-1:0]               out_left,
	output logic signed [SAMPLE_BITS-1:0]               out_right,
	output logic signed [ssgg_pkg::GAIN_W-1:0]          out_gain,
	output logic [ssgg_pkg::STEP_OUT_W-1:0]             out_step,
	output logic signed [MUL_A_W-1:0]                   mul_a,
	output logic signed [ssgg_pkg::MUL_B_W-1:0]         mul_b,
	input  logic signed [MUL_A_W+ssgg_pkg::MUL_B_W-1:0] mul_p,
	output ssgg_pkg::div_req_t                          div_req,
	input  ssgg_pkg::div_rsp_t                          div_rsp
);
	import ssgg_pkg::*;

	localparam int PW    = MUL_A_W + MUL_B_W;
	localparam int IW    = $clog2(MAX_STEPS);
	localparam int UP_SH = (PHASE_BITS > SYNC_W) ? PHASE_BITS - SYNC_W : 0;
	localparam int DN_SH = (PHASE_BITS < SYNC_W) ? SYNC_W - PHASE_BITS : 0;
	localparam logic signed [PW-1:0] RND  = PW'(32768);
	localparam logic signed [PW-1:0] SMAX = PW'({(SAMPLE_BITS-1){1'b1}});
	localparam logic signed [PW-1:0] SMIN = ~SMAX;

	typedef enum logic [3:0] {
		S_IDLE,
		S_POS_MUL,
		S_STEP,
		S_LEVELS,
		S_ATT_CHK,
		S_ATT_MUL,
		S_ATT_GO,
		S_ATT_DIV,
		S_REL_CHK,
		S_REL_MUL,
		S_REL_GO,
		S_REL_DIV,
		S_LEFT_MUL,
		S_LEFT_RES,
		S_DONE
	} state_t;

	state_t                        state_q;
	logic [PHASE_BITS-1:0]         phase_acc_q;
	logic [IW-1:0]                 active_q;
	logic [IW-1:0]                 previous_q;
	logic [IW-1:0]                 next_q;
	logic                          seen_q;
	logic signed [SAMPLE_BITS-1:0] sample_l_q;
	logic signed [SAMPLE_BITS-1:0] sample_r_q;
	logic [FRAC_W-1:0]             frac_q;
	logic [SPAN_W-1:0]             act_lv_q;
	logic [SPAN_W-1:0]             prv_lv_q;
	logic [SPAN_W-1:0]             nxt_lv_q;
	logic signed [GAIN_W-1:0]      vol_q;
	logic signed [SAMPLE_BITS-1:0] left_q;
	logic signed [MUL_A_W-1:0]     op_a_q;
	logic signed [MUL_B_W-1:0]     op_b_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_left_q;
	logic signed [SAMPLE_BITS-1:0] out_right_q;
	logic signed [GAIN_W-1:0]      out_gain_q;
	logic [STEP_OUT_W-1:0]         out_step_q;

	logic [PHASE_BITS+SYNC_W-1:0]  sync_x;
	logic [PHASE_BITS+INC_W-1:0]   inc_x;
	logic [PHASE_BITS-1:0]         sync_pos;
	logic [PHASE_BITS-1:0]         inc_pos;
	logic [PHASE_BITS-1:0]         pos;
	logic [STEPS_W-1:0]            steps_c;
	logic [STEPS_W-1:0]            idx_raw;
	logic [STEPS_W-1:0]            idx_c;
	logic [STEPS_W:0]              idx_inc;
	logic [IW-1:0]                 idx_w;
	logic [IW-1:0]                 nxt_c;
	logic [SPAN_W-1:0]             att_c;
	logic [SPAN_W-1:0]             rel_c;
	logic [SPAN_W-1:0]             thr;
	logic [SPAN_W-1:0]             diff_att;
	logic [SPAN_W-1:0]             diff_rel;
	logic [SPAN_W-1:0]             rel_num;
	logic signed [GAIN_W-1:0]      vol_att;
	logic signed [GAIN_W-1:0]      vol_rel;
	logic signed [PW-1:0]          rnd;
	logic signed [PW-1:0]          shr;
	logic signed [SAMPLE_BITS-1:0] sat_res;

	always_comb begin
		sync_x   = {{PHASE_BITS{1'b0}}, sync_phase} << UP_SH;
		sync_pos = PHASE_BITS'(sync_x >> DN_SH);
		inc_x    = {{PHASE_BITS{cfg.phase_inc[INC_W-1]}}, cfg.phase_inc} << UP_SH;
		inc_pos  = PHASE_BITS'(inc_x >> DN_SH);
		pos      = sync_valid ? sync_pos : phase_acc_q;

		if (cfg.step_count == '0) begin
			steps_c = STEPS_W'(1);
		end else if (32'(cfg.step_count) > MAX_STEPS) begin
			steps_c = STEPS_W'(MAX_STEPS);
		end else begin
			steps_c = cfg.step_count;
		end

		idx_raw = mul_p[PHASE_BITS +: STEPS_W];
		idx_c   = (idx_raw >= steps_c) ? steps_c - 1'b1 : idx_raw;
		idx_w   = IW'(idx_c);
		idx_inc = {1'b0, idx_c} + 1'b1;
		nxt_c   = (idx_inc < {1'b0, steps_c}) ? IW'(idx_inc) : '0;

		att_c    = clamp_span(cfg.attack_span);
		rel_c    = clamp_span(cfg.release_span);
		thr      = SPAN_ONE - rel_c;
		diff_att = act_lv_q - prv_lv_q;
		diff_rel = act_lv_q - nxt_lv_q;
		rel_num  = {1'b0, frac_q} - thr;
		vol_att  = $signed({1'b0, prv_lv_q}) + $signed({1'b0, div_rsp.quot});
		vol_rel  = vol_q - $signed({1'b0, div_rsp.quot});

		// round half up, then clip to the sample range
		rnd = mul_p + RND;
		shr = rnd >>> FRAC_W;
		if (shr > SMAX) begin
			sat_res = SAMPLE_BITS'(SMAX);
		end else if (shr < SMIN) begin
			sat_res = SAMPLE_BITS'(SMIN);
		end else begin
			sat_res = SAMPLE_BITS'(shr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_acc_q <= '0;
			active_q    <= '0;
			previous_q  <= '0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_DONE)) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						sample_l_q  <= sample_left;
						sample_r_q  <= sample_right;
						phase_acc_q <= pos + inc_pos;
						op_a_q      <= MUL_A_W'(pos);
						op_b_q      <= MUL_B_W'(steps_c);
						state_q     <= S_POS_MUL;
					end
				end
				S_POS_MUL: begin
					state_q <= S_STEP;
				end
				S_STEP: begin
					frac_q <= mul_p[PHASE_BITS-1 -: FRAC_W];
					next_q <= nxt_c;
					if (!seen_q) begin
						previous_q <= idx_w;
						active_q   <= idx_w;
						seen_q     <= 1'b1;
					end else if (active_q != idx_w) begin
						previous_q <= active_q;
						active_q   <= idx_w;
					end
					state_q <= S_LEVELS;
				end
				S_LEVELS: begin
					act_lv_q <= level_of(cfg.levels_low, cfg.levels_high,
						LVL_IDX_W'(active_q));
					prv_lv_q <= level_of(cfg.levels_low, cfg.levels_high,
						LVL_IDX_W'(previous_q));
					nxt_lv_q <= level_of(cfg.levels_low, cfg.levels_high,
						LVL_IDX_W'(next_q));
					state_q  <= S_ATT_CHK;
				end
				S_ATT_CHK: begin
					vol_q <= $signed({1'b0, act_lv_q});
					if (({1'b0, frac_q} < att_c) && (prv_lv_q < act_lv_q)) begin
						op_a_q  <= MUL_A_W'(frac_q);
						op_b_q  <= MUL_B_W'(diff_att);
						state_q <= S_ATT_MUL;
					end else begin
						state_q <= S_REL_CHK;
					end
				end
				S_ATT_MUL: begin
					state_q <= S_ATT_GO;
				end
				S_ATT_GO: begin
					state_q <= S_ATT_DIV;
				end
				S_ATT_DIV: begin
					if (div_rsp.done) begin
						vol_q   <= vol_att;
						state_q <= S_REL_CHK;
					end
				end
				S_REL_CHK: begin
					if (({1'b0, frac_q} > thr) && (nxt_lv_q < act_lv_q)) begin
						op_a_q  <= MUL_A_W'(rel_num);
						op_b_q  <= MUL_B_W'(diff_rel);
						state_q <= S_REL_MUL;
					end else begin
						op_a_q  <= MUL_A_W'(sample_l_q);
						op_b_q  <= vol_q;
						state_q <= S_LEFT_MUL;
					end
				end
				S_REL_MUL: begin
					state_q <= S_REL_GO;
				end
				S_REL_GO: begin
					state_q <= S_REL_DIV;
				end
				S_REL_DIV: begin
					if (div_rsp.done) begin
						vol_q   <= vol_rel;
						op_a_q  <= MUL_A_W'(sample_l_q);
						op_b_q  <= vol_rel;
						state_q <= S_LEFT_MUL;
					end
				end
				S_LEFT_MUL: begin
					op_a_q  <= MUL_A_W'(sample_r_q);
					state_q <= S_LEFT_RES;
				end
				S_LEFT_RES: begin
					left_q  <= sat_res;
					state_q <= S_DONE;
				end
				S_DONE: begin
					// right product stays in the multiplier while the output is held
					if (!out_valid_q || out_ready) begin
						out_left_q  <= left_q;
						out_right_q <= sat_res;
						out_gain_q  <= vol_q;
						out_step_q  <= STEP_OUT_W'(active_q);
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_left  = out_left_q;
	assign out_right = out_right_q;
	assign out_gain  = out_gain_q;
	assign out_step  = out_step_q;
	assign mul_a     = op_a_q;
	assign mul_b     = op_b_q;

	assign div_req.start = (state_q == S_ATT_GO) || (state_q == S_REL_GO);
	assign div_req.num   = mul_p[NUM_W-1:0];
	assign div_req.den   = (state_q == S_REL_GO) ? rel_c : att_c;

endmodule

`default_nettype wire

/* src/step_sequenced_gain_gate.sv */
// top level of the step sequenced stereo gain gate
//
//   port group   dir   contents
//   s_*          in    stereo sample beat, sync flag in s_tuser
//   m_*          out   gated stereo beat with gain and step
//   cfg_*        in    register writes, no read-back
//
// an item takes longer from accept to the next ready when the attack ramp is active,
// and longer still when the release ramp is active as well
// each ramp costs one multiply and one 17-bit division on the shared divider
// arst_n clears phase, step tracking and the output beat, and sets the registers to defaults
// s_tready is low from accept until the result is loaded into the output register
// a stalled output beat holds the last result while the next item is taken
`timescale 1ns / 1ps
`default_nettype none
`include "step_sequenced_gain_gate_defines.svh"

module step_sequenced_gain_gate #(
	parameter int MAX_STEPS   = 16,
	parameter int PHASE_BITS  = 24,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// sample_left, sample_right, sync_phase
	input  logic [((2*SAMPLE_BITS+24+7)/8)*8-1:0]     s_tdata,
	// sync_valid
	input  logic                                      s_tuser,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// out_left, out_right, gain_value, step_index
	output logic [((2*SAMPLE_BITS+22+7)/8)*8-1:0]     m_tdata,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	input  logic                                      cfg_wr_en,
	input  logic [ssgg_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  logic [ssgg_pkg::CFG_DATA_W-1:0]           cfg_data
);
	import ssgg_pkg::*;

	localparam int OUT_W   = ((2*SAMPLE_BITS+22+7)/8)*8;
	localparam int MUL_A_W = imax(imax(PHASE_BITS+1, SAMPLE_BITS), FRAC_W+1);

	cfg_t                          cfg_q;
	logic signed [SAMPLE_BITS-1:0] sample_left;
	logic signed [SAMPLE_BITS-1:0] sample_right;
	logic [SYNC_W-1:0]             sync_phase;
	logic signed [SAMPLE_BITS-1:0] out_left;
	logic signed [SAMPLE_BITS-1:0] out_right;
	logic signed [GAIN_W-1:0]      out_gain;
	logic [STEP_OUT_W-1:0]         out_step;
	logic signed [MUL_A_W-1:0]     mul_a;
	logic signed [MUL_B_W-1:0]     mul_b;
	logic signed [MUL_A_W+MUL_B_W-1:0] mul_p;
	div_req_t                      div_req;
	div_rsp_t                      div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_inc    <= RST_PHASE_INC;
			cfg_q.step_count   <= RST_STEP_COUNT;
			cfg_q.attack_span  <= RST_SPAN;
			cfg_q.release_span <= RST_SPAN;
			cfg_q.levels_low   <= RST_LEVELS;
			cfg_q.levels_high  <= RST_LEVELS;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PHASE_INC:    cfg_q.phase_inc    <= cfg_data[INC_W-1:0];
				REG_STEP_COUNT:   cfg_q.step_count   <= cfg_data[STEPS_W-1:0];
				REG_ATTACK_SPAN:  cfg_q.attack_span  <= cfg_data[SPAN_W-1:0];
				REG_RELEASE_SPAN: cfg_q.release_span <= cfg_data[SPAN_W-1:0];
				REG_LEVELS_LOW:   cfg_q.levels_low   <= cfg_data[LEVELS_W-1:0];
				REG_LEVELS_HIGH:  cfg_q.levels_high  <= cfg_data[LEVELS_W-1:0];
				default: ;
			endcase
		end
	end

	assign sample_left  = s_tdata[SAMPLE_BITS-1:0];
	assign sample_right = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
	assign sync_phase   = s_tdata[2*SAMPLE_BITS+SYNC_W-1:2*SAMPLE_BITS];

	assign m_tdata = OUT_W'({out_step, out_gain, out_right, out_left});

	ssgg_seq #(
		.MAX_STEPS  (MAX_STEPS),
		.PHASE_BITS (PHASE_BITS),
		.SAMPLE_BITS(SAMPLE_BITS),
		.MUL_A_W    (MUL_A_W)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.sample_left (sample_left),
		.sample_right(sample_right),
		.sync_valid  (s_tuser),
		.sync_phase  (sync_phase),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_left    (out_left),
		.out_right   (out_right),
		.out_gain    (out_gain),
		.out_step    (out_step),
		.mul_a       (mul_a),
		.mul_b       (mul_b),
		.mul_p       (mul_p),
		.div_req     (div_req),
		.div_rsp     (div_rsp)
	);

	ssgg_mul #(
		.A_W(MUL_A_W)
	) u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.product(mul_p)
	);

	ssgg_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	`SSGG_ASSERT(a_one_item_at_a_time, clk, arst_n, s_tvalid && s_tready |=> !s_tready)
	`SSGG_ASSERT(a_result_after_work, clk, arst_n, $rose(m_tvalid) |-> !$past(s_tready))
	`SSGG_ASSERT(a_gain_range, clk, arst_n, m_tvalid |-> (out_gain >= -18'sd65536) && (out_gain <= 18'sd65536))
	`SSGG_ASSERT_NR(a_reset_quiet, clk, !arst_n |-> !m_tvalid && s_tready)

endmodule

`default_nettype wire

/* bench/gain_gate_checker.sv */
// beat checker for the step sequenced gain gate: predicts each gated beat and compares it
`timescale 1ns / 1ps

module gain_gate_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [71:0]                       s_tdata,
	input  logic                              s_tuser,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [71:0]                       m_tdata,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic                              cfg_wr_en,
	input  logic [ssgg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ssgg_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                errors,
	output int                                beats_checked,
	output int                                leftover
);
	import ssgg_pkg::*;

	typedef struct packed {
		logic [3:0]          step_index;
		logic signed [17:0]  gain_value;
		logic signed [23:0]  out_right;
		logic signed [23:0]  out_left;
	} gated_beat_t;

	logic [24:0]  inc_reg;
	logic [4:0]   count_reg;
	logic [16:0]  attack_reg;
	logic [16:0]  release_reg;
	logic [127:0] level_bytes;
	logic [23:0]  seq_pos;
	int           cur_step;
	int           prev_step;
	bit           step_live;

	gated_beat_t gated_beats_due[$];

	function automatic longint span_used(input logic [16:0] v);
		longint s;
		s = longint'(v);
		if (s < 655) s = 655;
		if (s > 65536) s = 65536;
		return s;
	endfunction

	function automatic longint step_level(input int i);
		logic [7:0] b;
		b = level_bytes[i*8 +: 8];
		if (b > 8'd128) b = 8'd128;
		return longint'(b) << 9;
	endfunction

	function automatic logic signed [23:0] scale_sat(input logic signed [23:0] s,
		input longint g);
		longint q;
		q = (longint'(s) * g + 32768) >>> 16;
		if (q > 8388607) q = 8388607;
		if (q < -8388608) q = -8388608;
		return q[23:0];
	endfunction

	function automatic gated_beat_t gate_sample(input logic [71:0] beat, input logic sync);
		gated_beat_t r;
		logic [23:0] pos;
		longint steps, prod, idx, nxt, frac, att, rel, act, prv, nlv, vol;
		pos = sync ? beat[71:48] : seq_pos;
		seq_pos = pos + inc_reg[23:0];
		steps = longint'(count_reg);
		if (steps < 1) steps = 1;
		if (steps > 16) steps = 16;
		prod = longint'(pos) * steps;
		idx = prod >> 24;
		if (idx >= steps) idx = steps - 1;
		frac = (prod >> 8) & 64'hFFFF;
		if (!step_live) begin
			prev_step = int'(idx);
			cur_step = int'(idx);
			step_live = 1'b1;
		end else if (cur_step != idx) begin
			prev_step = cur_step;
			cur_step = int'(idx);
		end
		nxt = (idx + 1 < steps) ? idx + 1 : 0;
		att = span_used(attack_reg);
		rel = span_used(release_reg);
		act = step_level(cur_step);
		prv = step_level(prev_step);
		nlv = step_level(int'(nxt));
		vol = act;
		if (frac < att && prv < act)
			vol = prv + (frac * (act - prv)) / att;
		if (frac > 65536 - rel && nlv < act)
			vol = vol - ((frac - (65536 - rel)) * (act - nlv)) / rel;
		r.out_left = scale_sat(beat[23:0], vol);
		r.out_right = scale_sat(beat[47:24], vol);
		r.gain_value = vol[17:0];
		r.step_index = cur_step[3:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gated_beat_t want;
		gated_beat_t got;
		if (!arst_n) begin
			inc_reg = RST_PHASE_INC;
			count_reg = RST_STEP_COUNT;
			attack_reg = RST_SPAN;
			release_reg = RST_SPAN;
			level_bytes = '0;
			seq_pos = '0;
			cur_step = 0;
			prev_step = 0;
			step_live = 1'b0;
			gated_beats_due.delete();
			errors = 0;
			beats_checked = 0;
			leftover = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_PHASE_INC:    inc_reg = cfg_data[24:0];
					REG_STEP_COUNT:   count_reg = cfg_data[4:0];
					REG_ATTACK_SPAN:  attack_reg = cfg_data[16:0];
					REG_RELEASE_SPAN: release_reg = cfg_data[16:0];
					REG_LEVELS_LOW:   level_bytes[63:0] = cfg_data;
					REG_LEVELS_HIGH:  level_bytes[127:64] = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				gated_beats_due.push_back(gate_sample(s_tdata, s_tuser));
			if (m_tvalid && m_tready) begin
				got = gated_beat_t'(m_tdata[69:0]);
				if (gated_beats_due.size() == 0) begin
					errors++;
					$error("output beat with no sample pending");
				end else begin
					want = gated_beats_due.pop_front();
					beats_checked++;
					if (got.out_left !== want.out_left) begin
						errors++;
						$error("out_left expected %0d actual %0d", want.out_left, got.out_left);
					end
					if (got.out_right !== want.out_right) begin
						errors++;
						$error("out_right expected %0d actual %0d", want.out_right,
							got.out_right);
					end
					if (got.gain_value !== want.gain_value) begin
						errors++;
						$error("gain_value expected %0d actual %0d", want.gain_value,
							got.gain_value);
					end
					if (got.step_index !== want.step_index) begin
						errors++;
						$error("step_index expected %0d actual %0d", want.step_index,
							got.step_index);
					end
				end
			end
			leftover = gated_beats_due.size();
		end
	end

endmodule

/* bench/step_sequenced_gain_gate_tb.sv */
// testbench top for the step sequenced gain gate: stimulus, flow control and verdict
`timescale 1ns / 1ps

module step_sequenced_gain_gate_tb;
	import ssgg_pkg::*;

	localparam int     CYCLE_LIMIT  = 1000000;
	localparam int     RAND_PHASES  = 8;
	localparam int     PHASE_ITEMS  = 188;
	localparam int     HOLD_CYCLES  = 400;
	localparam int     TAIL_CYCLES  = 60;
	localparam logic [63:0] LEVELS_LO = 64'h20FF_4020_0010_8060;
	localparam logic [63:0] LEVELS_HI = 64'h8100_7F01_C080_0530;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic [71:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] m_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic        cfg_wr_en = 1'b0;
	cfg_reg_t    cfg_index = REG_PHASE_INC;
	logic [63:0] cfg_data = '0;

	int errors;
	int beats_checked;
	int leftover;
	int sent = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit hold_long = 1'b0;

	always #4 clk = ~clk;

	step_sequenced_gain_gate DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	gain_gate_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.m_tdata       (m_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.beats_checked (beats_checked),
		.leftover      (leftover)
	);

	// s_tdata: sample_left, sample_right, sync_phase; s_tuser: sync_valid
	task automatic offer_sample(input logic [23:0] l, input logic [23:0] r,
		input logic sync, input logic [23:0] ph);
		s_tdata <= {ph, r, l};
		s_tuser <= sync;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic drain_gate();
		s_tvalid <= 1'b0;
		wait (beats_checked == sent);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_gate(input logic [24:0] inc, input logic [4:0] cnt,
		input logic [16:0] att, input logic [16:0] rel,
		input logic [63:0] lo, input logic [63:0] hi);
		write_reg(REG_PHASE_INC, 64'(inc));
		write_reg(REG_STEP_COUNT, 64'(cnt));
		write_reg(REG_ATTACK_SPAN, 64'(att));
		write_reg(REG_RELEASE_SPAN, 64'(rel));
		write_reg(REG_LEVELS_LOW, lo);
		write_reg(REG_LEVELS_HIGH, hi);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [23:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'h000000;
			default: return 24'($urandom());
		endcase
	endfunction

	function automatic logic [16:0] pick_span();
		case ($urandom_range(0, 5))
			0: return 17'd655;
			1: return 17'd65536;
			2: return 17'd0;
			3: return 17'h1FFFF;
			4: return 17'($urandom());
			default: return 17'($urandom_range(655, 65536));
		endcase
	endfunction

	function automatic logic [63:0] pick_levels();
		logic [63:0] v;
		int k;
		for (k = 0; k < 8; k++) begin
			case ($urandom_range(0, 9))
				0, 1: v[k*8 +: 8] = 8'd0;
				2, 3: v[k*8 +: 8] = 8'd128;
				4:    v[k*8 +: 8] = 8'($urandom_range(129, 255));
				default: v[k*8 +: 8] = 8'($urandom_range(0, 128));
			endcase
		end
		return v;
	endfunction

	task automatic random_setup();
		logic [24:0] inc;
		logic [4:0]  cnt;
		case ($urandom_range(0, 5))
			0: inc = 25'd0;
			1: inc = -25'sd8388608;
			2: inc = 25'd8388608;
			3: inc = 25'($urandom_range(1, 4096));
			4: inc = -25'($urandom_range(1, 4096));
			default: inc = 25'($urandom());
		endcase
		case ($urandom_range(0, 4))
			0: cnt = 5'd1;
			1: cnt = 5'd16;
			2: cnt = 5'd0;
			3: cnt = 5'd31;
			default: cnt = 5'($urandom_range(0, 31));
		endcase
		load_gate(inc, cnt, pick_span(), pick_span(), pick_levels(), pick_levels());
	endtask

	// output side flow control
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				hold_long = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	initial begin
		int p;
		int n;
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first beat after reset, register defaults
		offer_sample(24'h800000, 24'h7FFFFF, 1'b1, 24'h500400);
		drain_gate();
		load_gate(25'd0, 5'd16, 17'd13107, 17'd13107, LEVELS_LO, LEVELS_HI);
		// zero increment holds position on step 5
		offer_sample(24'h7FFFFF, 24'h800000, 1'b0, 24'hA5A5A5);
		// attack from step 5 into capped step 6
		offer_sample(24'h000000, 24'hFFFFFF, 1'b1, 24'h600800);
		// release toward lower step 7
		offer_sample(24'h7FFFFF, 24'h123456, 1'b1, 24'h6F0000);
		// last step, next wraps to step 0
		offer_sample(24'h800000, 24'h7FFFFF, 1'b1, 24'hFFFFFF);
		offer_sample(24'h400000, 24'hC00000, 1'b1, 24'h000000);
		drain_gate();

		load_gate(25'h0100000, 5'd3, 17'd655, 17'd65536, LEVELS_LO, LEVELS_HI);
		for (n = 0; n < 5; n++)
			offer_sample(pick_sample(), pick_sample(), 1'b0, 24'($urandom()));
		drain_gate();

		// step count and attack span below range, release span above range
		load_gate(-25'sd8388608, 5'd0, 17'd0, 17'h1FFFF, LEVELS_LO, LEVELS_HI);
		for (n = 0; n < 3; n++)
			offer_sample(pick_sample(), pick_sample(), 1'b0, 24'($urandom()));
		drain_gate();

		// step count and attack span above range, release span below range
		load_gate(25'd8388608, 5'd31, 17'h1FFFF, 17'd0, LEVELS_LO, LEVELS_HI);
		offer_sample(24'h7FFFFF, 24'h800000, 1'b1, 24'h6FFF00);
		offer_sample(24'h7FFFFF, 24'h800000, 1'b1, 24'hAFFFFF);
		offer_sample(24'h800000, 24'h7FFFFF, 1'b0, 24'h000000);
		drain_gate();

		// attack and release spans overlap
		load_gate(25'h0001000, 5'd16, 17'd65536, 17'd65536, LEVELS_LO, LEVELS_HI);
		offer_sample(24'h7FFFFF, 24'h7FFFFF, 1'b1, 24'hA08000);
		offer_sample(24'h800000, 24'h800000, 1'b1, 24'hB0F000);
		offer_sample(24'h7FFFFF, 24'h800000, 1'b1, 24'hB00100);
		offer_sample(24'h555555, 24'hAAAAAA, 1'b0, 24'h000000);
		drain_gate();

		for (p = 0; p < RAND_PHASES; p++) begin
			random_setup();
			tx_idle_on = (p != 3 && p != RAND_PHASES - 1);
			rx_idle_on = (p != 4 && p != RAND_PHASES - 1);
			if (p == 2)
				hold_long = 1'b1;
			for (n = 0; n < PHASE_ITEMS; n++)
				offer_sample(pick_sample(), pick_sample(), $urandom_range(0, 19) == 0,
					24'($urandom()));
			drain_gate();
		end

		if (errors == 0 && leftover == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+src
src/ssgg_pkg.sv
src/ssgg_mul.sv
src/ssgg_div.sv
src/ssgg_seq.sv
src/step_sequenced_gain_gate.sv
bench/gain_gate_checker.sv
bench/step_sequenced_gain_gate_tb.sv
